[sv/oocm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oocm_pkg
// Shared types and constants for the object overlap counter map.
// ----------------------------------------------------------------------------
package oocm_pkg;

  localparam int XY_W      = 9;
  localparam int MASK_W    = 8;
  localparam int COV_W     = 8;
  localparam int AREA_W    = 19;
  localparam int TOTAL_W   = 32;
  localparam int TALLY_W   = 16;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 88;
  localparam int MEMBER_BIT = 7;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;

  localparam logic [COV_W-1:0]   COVER_MAX = 8'd255;
  localparam logic [COV_W-1:0]   COVER_ONE = 8'd1;
  localparam logic [AREA_W-1:0]  AREA_MAX  = 19'h7FFFF;
  localparam logic [TALLY_W-1:0] TALLY_MAX = 16'hFFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_MARK  = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  typedef struct packed {
    op_t  op;
    logic member;
    logic last;
  } pix_ctl_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } back_st_t;

endpackage
`default_nettype wire

[sv/object_overlap_counter_map_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// object_overlap_counter_map_core
// Per-pixel coverage map with per-object overlap counting and check pass.
// ----------------------------------------------------------------------------
// Each pixel runs the map read-modify-write in the back (registered read in
// ST_IDLE, then write in ST_EXEC) before the next is popped. A request that
// ends an object passes the front register, the queue and both back states before out_tvalid rises.
// Reset: synchronous; counters and config cleared, then the coverage map is
// swept to zero, address by address, with in_tready held low.
// ----------------------------------------------------------------------------
module object_overlap_counter_map_core #(
  parameter int IMAGE_WIDTH  = 512,
  parameter int IMAGE_HEIGHT = 512
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [oocm_pkg::IN_DATA_W-1:0]      in_tdata,  // pixel_x, pixel_y, mask_byte
  input  wire logic                                in_tuser,  // opcode
  input  wire logic                                in_tlast,  // object_last
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // object_overlap, total_overlap, max_overlap, overlapping_objects, select_object
  output logic [oocm_pkg::OUT_DATA_W-1:0]          out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [oocm_pkg::AREA_W-1:0]         cfg_data   // acceptable_overlap
);
  import oocm_pkg::*;

  localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW     = $bits(pix_ctl_t) + ADDR_W;

  logic [AREA_W-1:0]  acc_r;
  logic               clear_busy;
  logic               f_valid, q_full, q_empty, q_pop;
  pix_ctl_t           f_ctl, q_ctl;
  logic [ADDR_W-1:0]  f_addr, q_addr;
  logic [QW-1:0]      q_out;
  logic [AREA_W-1:0]  r_area, r_max;
  logic [TOTAL_W-1:0] r_total;
  logic [TALLY_W-1:0] r_tally;
  logic               r_sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cfg_valid) begin
      acc_r <= cfg_data;
    end
  end

  oocm_front #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .ADDR_W       (ADDR_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear_busy (clear_busy),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .op         (op_t'(in_tuser)),
    .pix_x      (in_tdata[8:0]),
    .pix_y      (in_tdata[17:9]),
    .mask       (in_tdata[25:18]),
    .last       (in_tlast),
    .req_valid  (f_valid),
    .req_full   (q_full),
    .req_ctl    (f_ctl),
    .req_addr   (f_addr)
  );

  oocm_fifo #(
    .W (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data ({f_ctl, f_addr}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  assign q_ctl  = q_out[QW-1:ADDR_W];
  assign q_addr = q_out[ADDR_W-1:0];

  oocm_back #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear_busy (clear_busy),
    .req_empty  (q_empty),
    .req_pop    (q_pop),
    .req_ctl    (q_ctl),
    .req_addr   (q_addr),
    .acc_lim    (acc_r),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_area   (r_area),
    .res_total  (r_total),
    .res_max    (r_max),
    .res_tally  (r_tally),
    .res_sel    (r_sel)
  );

  assign out_tdata = {1'b0, r_sel, r_tally, r_max, r_total, r_area};

endmodule
`default_nettype wire

[sv/oocm_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oocm_fifo
// Short request queue between the classifying front and the coverage back.
// ----------------------------------------------------------------------------
module oocm_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);
  import oocm_pkg::*;

  logic [W-1:0]      q_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/oocm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oocm_front
// Accepts pixel requests, clips them to the image and forms the map address.
// ----------------------------------------------------------------------------
module oocm_front #(
  parameter int IMAGE_WIDTH  = 512,
  parameter int IMAGE_HEIGHT = 512,
  parameter int ADDR_W       = 18
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      clear_busy,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire oocm_pkg::op_t             op,
  input  wire logic [oocm_pkg::XY_W-1:0] pix_x,
  input  wire logic [oocm_pkg::XY_W-1:0] pix_y,
  input  wire logic [7:0]                mask,
  input  wire logic                      last,
  output logic                           req_valid,
  input  wire logic                      req_full,
  output oocm_pkg::pix_ctl_t             req_ctl,
  output logic [ADDR_W-1:0]              req_addr
);
  import oocm_pkg::*;

  localparam int CW = 13;
  localparam int PW = 24;

  logic              vld_r;
  pix_ctl_t          ctl_r, ctl_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [PW-1:0]     lin;
  logic              in_img;

  assign in_img = (CW'(pix_x) < CW'(IMAGE_WIDTH)) && (CW'(pix_y) < CW'(IMAGE_HEIGHT));
  assign lin    = PW'(pix_y) * PW'(IMAGE_WIDTH) + PW'(pix_x);

  always_comb begin
    ctl_nxt.op     = op;
    ctl_nxt.member = mask[MEMBER_BIT] && in_img;
    ctl_nxt.last   = last;
  end

  assign in_ready  = !clear_busy && (!vld_r || !req_full);
  assign req_valid = vld_r;
  assign req_ctl   = ctl_r;
  assign req_addr  = addr_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ctl_r  <= ctl_nxt;
      addr_r <= lin[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (!req_full) begin
      vld_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[sv/oocm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oocm_back
// Coverage map read-modify-write, per-object counting and result register.
// ----------------------------------------------------------------------------
module oocm_back #(
  parameter int DEPTH  = 262144,
  parameter int ADDR_W = 18
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  output logic                              clear_busy,
  input  wire logic                         req_empty,
  output logic                              req_pop,
  input  wire oocm_pkg::pix_ctl_t           req_ctl,
  input  wire logic [ADDR_W-1:0]            req_addr,
  input  wire logic [oocm_pkg::AREA_W-1:0]  acc_lim,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output logic [oocm_pkg::AREA_W-1:0]       res_area,
  output logic [oocm_pkg::TOTAL_W-1:0]      res_total,
  output logic [oocm_pkg::AREA_W-1:0]       res_max,
  output logic [oocm_pkg::TALLY_W-1:0]      res_tally,
  output logic                              res_sel
);
  import oocm_pkg::*;

  logic [COV_W-1:0]   cov_mem [DEPTH];
  logic [COV_W-1:0]   rdata_r;

  back_st_t           st_r, st_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  pix_ctl_t           cur_r;
  logic [ADDR_W-1:0]  cur_addr_r;

  logic [AREA_W-1:0]  area_r, area_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [AREA_W-1:0]  max_r, max_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic               ovld_r, ovld_nxt;
  logic [AREA_W-1:0]  oarea_r;
  logic               osel_r;

  logic               mem_re, mem_we, finish, hit, take;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [COV_W-1:0]   mem_wdata;
  logic [AREA_W-1:0]  area_inc;
  logic [TOTAL_W:0]   sum;

  always_ff @(posedge clk) begin
    if (mem_we) cov_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= cov_mem[req_addr];
  end

  always_comb begin
    if (cur_r.op == OP_MARK) hit = cur_r.member && (rdata_r != '0);
    else                     hit = cur_r.member && (rdata_r > COVER_ONE);
    area_inc = (hit && area_r != AREA_MAX) ? area_r + 1'b1 : area_r;
    sum      = {1'b0, total_r} + (TOTAL_W+1)'(area_inc);
  end

  always_comb begin
    st_nxt    = st_r;
    clr_nxt   = clr_r;
    req_pop   = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = '0;
    take      = 1'b0;
    finish    = 1'b0;
    area_nxt  = area_r;
    total_nxt = total_r;
    max_nxt   = max_r;
    tally_nxt = tally_r;
    ovld_nxt  = ovld_r && !res_ready;
    unique case (st_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(DEPTH - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!req_empty) begin
          req_pop = 1'b1;
          take    = 1'b1;
          mem_re  = req_ctl.member;
          st_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        finish = !cur_r.last || !ovld_r || res_ready;
        if (finish) begin
          st_nxt    = ST_IDLE;
          mem_waddr = cur_addr_r;
          mem_wdata = rdata_r + 1'b1;
          mem_we    = cur_r.member && cur_r.op == OP_MARK && rdata_r != COVER_MAX;
          area_nxt  = area_inc;
          if (cur_r.last) begin
            area_nxt = '0;
            ovld_nxt = 1'b1;
            if (cur_r.op == OP_MARK) begin
              total_nxt = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
              if (area_inc > max_r) max_nxt = area_inc;
              if (area_inc != '0 && tally_r != TALLY_MAX) tally_nxt = tally_r + 1'b1;
            end
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_CLEAR;
      clr_r   <= '0;
      area_r  <= '0;
      total_r <= '0;
      max_r   <= '0;
      tally_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      clr_r   <= clr_nxt;
      area_r  <= area_nxt;
      total_r <= total_nxt;
      max_r   <= max_nxt;
      tally_r <= tally_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r      <= req_ctl;
      cur_addr_r <= req_addr;
    end
    if (finish && cur_r.last) begin
      oarea_r <= area_inc;
      osel_r  <= (cur_r.op == OP_CHECK) && (area_inc > acc_lim);
    end
  end

  assign clear_busy = (st_r == ST_CLEAR);
  assign res_valid  = ovld_r;
  assign res_area   = oarea_r;
  assign res_total  = total_r;
  assign res_max    = max_r;
  assign res_tally  = tally_r;
  assign res_sel    = osel_r;

endmodule
`default_nettype wire

[tb/overlap_map_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlap_map_monitor
// Watches the pixel, result and threshold channels of the overlap counter map.
// Keeps its own coverage map and running totals, predicts the report for each
// object and compares every delivered report against the oldest prediction.
// ----------------------------------------------------------------------------
module overlap_map_monitor #(
  parameter int IMAGE_WIDTH  = 512,
  parameter int IMAGE_HEIGHT = 512
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [oocm_pkg::IN_DATA_W-1:0]  in_tdata,  // pixel_x, pixel_y, mask_byte
  input  wire logic                           in_tuser,  // opcode
  input  wire logic                           in_tlast,  // object_last
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  // object_overlap, total_overlap, max_overlap, overlapping_objects, select_object
  input  wire logic [oocm_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [oocm_pkg::AREA_W-1:0]     cfg_data,  // acceptable_overlap
  output int                                  errors,
  output int                                  pending,
  output int                                  reports
);
  import oocm_pkg::*;

  localparam int TOT_LSB   = AREA_W;
  localparam int MAX_LSB   = TOT_LSB + TOTAL_W;
  localparam int TALLY_LSB = MAX_LSB + AREA_W;
  localparam int SEL_BIT   = TALLY_LSB + TALLY_W;

  typedef struct {
    logic [AREA_W-1:0]  object_overlap;
    logic [TOTAL_W-1:0] total_overlap;
    logic [AREA_W-1:0]  max_overlap;
    logic [TALLY_W-1:0] overlapping_objects;
    logic               select_object;
  } overlap_report_t;

  overlap_report_t    expected_reports[$];
  overlap_report_t    rep;
  logic [COV_W-1:0]   coverage [IMAGE_WIDTH*IMAGE_HEIGHT];
  logic [AREA_W-1:0]  object_area;
  logic [AREA_W-1:0]  max_area;
  logic [AREA_W-1:0]  threshold;
  logic [TOTAL_W-1:0] total_area;
  logic [TALLY_W-1:0] overlap_tally;
  logic [TOTAL_W:0]   sum;
  logic [XY_W-1:0]    px;
  logic [XY_W-1:0]    py;
  logic [MASK_W-1:0]  mask;
  op_t                op;
  logic               hit;
  int                 addr;

  initial begin
    for (int i = 0; i < IMAGE_WIDTH*IMAGE_HEIGHT; i++) coverage[i] = '0;
    object_area   = '0;
    max_area      = '0;
    threshold     = '0;
    total_area    = '0;
    overlap_tally = '0;
    errors        = 0;
    pending       = 0;
    reports       = 0;
  end

  task automatic check_field(input string field, input logic [TOTAL_W-1:0] want,
                             input logic [TOTAL_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) threshold = cfg_data;

      if (in_tvalid && in_tready) begin
        op   = op_t'(in_tuser);
        px   = in_tdata[0 +: XY_W];
        py   = in_tdata[XY_W +: XY_W];
        mask = in_tdata[2*XY_W +: MASK_W];
        hit  = 1'b0;
        if (mask[MEMBER_BIT] && px < IMAGE_WIDTH && py < IMAGE_HEIGHT) begin
          addr = py * IMAGE_WIDTH + px;
          if (op == OP_MARK) begin
            hit = (coverage[addr] != '0);
            if (coverage[addr] != COVER_MAX) coverage[addr] = coverage[addr] + 1'b1;
          end else begin
            hit = (coverage[addr] > COVER_ONE);
          end
          if (hit && object_area != AREA_MAX) object_area = object_area + 1'b1;
        end
        if (in_tlast) begin
          rep.select_object = 1'b0;
          if (op == OP_MARK) begin
            sum = {1'b0, total_area} + (TOTAL_W+1)'(object_area);
            total_area = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            if (object_area > max_area) max_area = object_area;
            if (object_area != '0 && overlap_tally != TALLY_MAX)
              overlap_tally = overlap_tally + 1'b1;
          end else begin
            rep.select_object = (object_area > threshold);
          end
          rep.object_overlap      = object_area;
          rep.total_overlap       = total_area;
          rep.max_overlap         = max_area;
          rep.overlapping_objects = overlap_tally;
          expected_reports.push_back(rep);
          object_area = '0;
        end
      end

      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual tdata %h",
                   $time, out_tdata);
        end else begin
          rep = expected_reports.pop_front();
          check_field("object_overlap", TOTAL_W'(rep.object_overlap),
                      TOTAL_W'(out_tdata[0 +: AREA_W]));
          check_field("total_overlap", rep.total_overlap, out_tdata[TOT_LSB +: TOTAL_W]);
          check_field("max_overlap", TOTAL_W'(rep.max_overlap),
                      TOTAL_W'(out_tdata[MAX_LSB +: AREA_W]));
          check_field("overlapping_objects", TOTAL_W'(rep.overlapping_objects),
                      TOTAL_W'(out_tdata[TALLY_LSB +: TALLY_W]));
          check_field("select_object", TOTAL_W'(rep.select_object),
                      TOTAL_W'(out_tdata[SEL_BIT]));
          reports++;
        end
      end

      pending = expected_reports.size();
    end
  end

endmodule

[tb/tb_object_overlap_counter_map_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_object_overlap_counter_map_core
// Streams object mask pixels through the overlap counter map in mark and check
// passes under several overlap thresholds, with random gaps and backpressure,
// and takes the verdict from the channel monitor.
// ----------------------------------------------------------------------------
module tb_object_overlap_counter_map_core;
  import oocm_pkg::*;

  localparam int IMG_W        = 500;
  localparam int IMG_H        = 500;
  localparam int IDLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES       = 6;
  localparam int PHASE_PIXELS = 115;
  localparam int SAT_RUN      = 270;
  localparam int LONG_HOLD    = 600;
  localparam int HOT_X        = 7;
  localparam int HOT_Y        = 3;
  localparam int WIN_X        = 40;
  localparam int WIN_Y        = 60;
  localparam int WIN_SPAN     = 5;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [AREA_W-1:0]     cfg_data;

  int   errors;
  int   pending;
  int   reports;
  int   pixels_sent;
  int   objects_sent;
  int   cfg_writes;
  logic no_gaps;

  object_overlap_counter_map_core #(
    .IMAGE_WIDTH (IMG_W),
    .IMAGE_HEIGHT(IMG_H)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  overlap_map_monitor #(
    .IMAGE_WIDTH (IMG_W),
    .IMAGE_HEIGHT(IMG_H)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .reports   (reports)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_cycles();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // entered and left at a falling edge; valid stays up only when the next
  // request follows at once
  task automatic push_pixel(input op_t op, input logic [XY_W-1:0] x,
                            input logic [XY_W-1:0] y, input logic [MASK_W-1:0] m,
                            input logic last);
    int g;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-2*XY_W-MASK_W){1'b0}}, m, y, x};
    in_tuser  <= op;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    pixels_sent++;
    if (last) objects_sent++;
    g = no_gaps ? 0 : gap_cycles();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic write_threshold(input logic [AREA_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // result side: random stalls, stall-free stretches, one long hold
  initial begin : result_sink
    int   stall_left;
    int   free_left;
    logic hold_done;
    stall_left = 0;
    free_left  = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!hold_done && reports >= 60) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
        free_left  = 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (free_left > 0) begin
        out_tready <= 1'b1;
        free_left--;
      end else begin
        if ($urandom_range(0, 99) < 4) free_left = $urandom_range(50, 200);
        stall_left = ($urandom_range(0, 99) < 30) ? gap_cycles() : 0;
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    op_t               op;
    op_t               pix_op;
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
    logic [MASK_W-1:0] m;
    logic [AREA_W-1:0] thr;
    int                r;
    int                len;
    int                budget;

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    in_tlast     = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    no_gaps      = 1'b0;
    pixels_sent  = 0;
    objects_sent = 0;
    cfg_writes   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_threshold('0);

    // self overlap, non-member last, clipped pixels, mixed opcodes
    push_pixel(OP_MARK,  9'd0,   9'd0,   8'hFF, 1'b0);
    push_pixel(OP_MARK,  9'd0,   9'd0,   8'h80, 1'b1);
    push_pixel(OP_MARK,  9'd499, 9'd499, 8'h7F, 1'b1);
    push_pixel(OP_MARK,  9'd500, 9'd10,  8'hFF, 1'b0);
    push_pixel(OP_MARK,  9'd10,  9'd500, 8'hFF, 1'b0);
    push_pixel(OP_MARK,  9'd511, 9'd511, 8'hFF, 1'b1);
    push_pixel(OP_CHECK, 9'd0,   9'd0,   8'h80, 1'b0);
    push_pixel(OP_CHECK, 9'd0,   9'd0,   8'hFF, 1'b1);
    push_pixel(OP_CHECK, 9'd1,   9'd1,   8'hFF, 1'b1);
    push_pixel(OP_MARK,  9'd0,   9'd0,   8'h00, 1'b0);
    push_pixel(OP_MARK,  9'd0,   9'd0,   8'hC0, 1'b0);
    push_pixel(OP_CHECK, 9'd0,   9'd0,   8'h80, 1'b0);
    push_pixel(OP_MARK,  9'd499, 9'd0,   8'h80, 1'b1);
    push_pixel(OP_CHECK, 9'd0,   9'd499, 8'h80, 1'b0);
    push_pixel(OP_MARK,  9'd0,   9'd0,   8'h80, 1'b0);
    push_pixel(OP_CHECK, 9'd511, 9'd0,   8'h80, 1'b1);
    push_pixel(OP_MARK,  9'd255, 9'd256, 8'hAA, 1'b1);
    push_pixel(OP_CHECK, 9'd255, 9'd256, 8'h55, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       thr = AREA_MAX;
        1:       thr = 19'd1;
        2:       thr = AREA_W'($urandom_range(0, 6));
        3:       thr = 19'd262144;
        4:       thr = AREA_W'($urandom);
        default: thr = 19'd3;
      endcase
      write_threshold(thr);

      if (p == 3) begin
        // drive one pixel's coverage into saturation
        no_gaps = 1'b0;
        for (int i = 0; i < SAT_RUN; i++)
          push_pixel(OP_MARK, XY_W'(HOT_X), XY_W'(HOT_Y),
                     8'h80 | MASK_W'($urandom_range(0, 127)), i == SAT_RUN - 1);
        push_pixel(OP_CHECK, XY_W'(HOT_X), XY_W'(HOT_Y), 8'hFF, 1'b1);
      end

      budget = pixels_sent + PHASE_PIXELS;
      while (pixels_sent < budget) begin
        no_gaps = ($urandom_range(0, 99) < 20);
        if ($urandom_range(0, 99) < 85) begin
          op  = ($urandom_range(0, 99) < 60) ? OP_MARK : OP_CHECK;
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
              x = XY_W'(HOT_X);
              y = XY_W'(HOT_Y);
              m = 8'h80 | MASK_W'($urandom_range(0, 127));
            end else if (r < 90) begin
              x = XY_W'(WIN_X + $urandom_range(0, WIN_SPAN));
              y = XY_W'(WIN_Y + $urandom_range(0, WIN_SPAN));
              m = (r < 75) ? (8'h80 | MASK_W'($urandom_range(0, 127)))
                           : MASK_W'($urandom_range(0, 127));
            end else begin
              x = XY_W'($urandom);
              y = XY_W'($urandom);
              m = MASK_W'($urandom);
            end
            pix_op = op;
            if ($urandom_range(0, 9) == 0) pix_op = (op == OP_MARK) ? OP_CHECK : OP_MARK;
            push_pixel(pix_op, x, y, m, i == len - 1);
          end
        end else begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++)
            push_pixel(op_t'($urandom_range(0, 1)), XY_W'($urandom), XY_W'($urandom),
                       MASK_W'($urandom), i == len - 1);
        end
      end
    end

    in_tvalid <= 1'b0;
    no_gaps = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d pixels in %0d objects under %0d threshold settings, %0d reports checked",
             pixels_sent, objects_sent, cfg_writes, reports);
    $display("Map %0dx%0d with clipped pixels, one pixel driven to coverage saturation",
             IMG_W, IMG_H);
    if (errors == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
